/* hdl/vrt_pkg.sv */
package vrt_pkg;

    // Fixed widths of the configuration registers and result codes.
    localparam int STEP_W     = 10;
    localparam int NUDGE_W    = 16;
    localparam int TIME_W     = 31;
    localparam int TIME_LO_W  = 16;
    localparam int TIME_HI_W  = TIME_W - TIME_LO_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int FACE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int IO_W       = 32;

    localparam logic [STEP_W-1:0]  STEP_LIMIT_RST  = 10'd250;
    localparam logic [NUDGE_W-1:0] FLOOR_NUDGE_RST = 16'd328;
    localparam logic [TIME_W-1:0]  MAX_TIME_RST    = 31'd13107200;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_NUDGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME    = 2'd2;

    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_CONTINUE = 1'b1;

    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd3;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd4;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_VOXEL = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEST  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd3;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MOVE,
        ST_PUSH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  decide;
        logic  div_start;
        logic  div_step;
        logic  take;
        logic  mul_lo;
        logic  mul_hi;
        logic  move;
        logic  push;
        axis_t axis;
    } vrt_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [STATUS_W-1:0] verdict;
        logic                dir_zero;
        logic                div_done;
        logic                out_free;
    } vrt_stat_t;

    function automatic logic [FACE_W-1:0] axis_face(input axis_t axis, input logic neg);
        logic [FACE_W-1:0] f;
        begin
            case (axis)
                AXIS_X:  f = neg ? FACE_FRONT : FACE_BACK;
                AXIS_Y:  f = neg ? FACE_TOP : FACE_BOTTOM;
                default: f = neg ? FACE_RIGHT : FACE_LEFT;
            endcase
            return f;
        end
    endfunction

endpackage

/* hdl/voxel_ray_traversal_core.sv */
// Voxel ray traversal core. A request with cmd = start loads a ray from start_* to end_*
// (signed fixed point with FRAC_BITS fraction bits, Q16.16 by default) and returns the first
// voxel to test; a request with cmd = continue means the last reported voxel was empty and
// returns the next one. Every request produces exactly one result: a segment midpoint inside
// the voxel with the face it was entered by (status 0), or the end of the ray because the
// destination voxel was reached (status 1) or step_limit steps were taken (status 2), or
// status 3 with zeroed fields when no ray is active. Each request is handled on its own. In
// a stepping request, the crossing time of every axis with a nonzero direction goes through
// one shared restoring divider with DW = max(FRAC_BITS + 2, 18) + FRAC_BITS quotient bits
// that retires one quotient bit per cycle, and each axis is then moved with a two-pass
// multiply of the crossing time, split into 16-bit and 15-bit halves, by its direction. An
// axis with zero direction skips its division. The next request is taken as soon as the
// result is in the output register, while it waits to be read; a result that is still
// waiting when the next one is ready holds the block in its push state. Configuration
// writes are taken in every cycle and must be made while no request is in flight.
module voxel_ray_traversal_core
#(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [vrt_pkg::IO_W-1:0]       start_x,
    input  logic [vrt_pkg::IO_W-1:0]       start_y,
    input  logic [vrt_pkg::IO_W-1:0]       start_z,
    input  logic [vrt_pkg::IO_W-1:0]       end_x,
    input  logic [vrt_pkg::IO_W-1:0]       end_y,
    input  logic [vrt_pkg::IO_W-1:0]       end_z,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vrt_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vrt_pkg::IO_W-1:0]       mid_x,
    output logic [vrt_pkg::IO_W-1:0]       mid_y,
    output logic [vrt_pkg::IO_W-1:0]       mid_z,
    output logic [vrt_pkg::FACE_W-1:0]     entry_face,
    output logic [vrt_pkg::STATUS_W-1:0]   status
);

    vrt_pkg::vrt_ctl_t  ctl;
    vrt_pkg::vrt_stat_t stat;

    // The controller sequences checks, divisions, multiplies and the result push.
    vrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // The datapath holds the ray, the configuration and the result register.
    vrt_datapath
    #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .req_cmd    (cmd),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .end_x      (end_x),
        .end_y      (end_y),
        .end_z      (end_z),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mid_x      (mid_x),
        .mid_y      (mid_y),
        .mid_z      (mid_z),
        .entry_face (entry_face),
        .status     (status)
    );

    // A result is never pushed while a new request can be taken.
    assert property (@(posedge clk) disable iff (!rst_n) ctl.push |-> !in_ready)
        else $error("result push overlaps request acceptance");

    // The divider is never stepped past its last quotient bit.
    assert property (@(posedge clk) disable iff (!rst_n) ctl.div_step |-> !stat.div_done)
        else $error("divider stepped after completion");

    // A result without an active ray carries zeroed fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == vrt_pkg::STATUS_NONE)
        |-> (mid_x == '0 && mid_y == '0 && mid_z == '0 && entry_face == vrt_pkg::FACE_FRONT))
        else $error("no-ray result carries nonzero fields");

endmodule

/* hdl/vrt_ctrl.sv */
module vrt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vrt_pkg::vrt_stat_t stat,
    output vrt_pkg::vrt_ctl_t  ctl
);

    vrt_pkg::ctrl_state_t state_reg, state_next;
    vrt_pkg::axis_t       axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vrt_pkg::ST_IDLE;
            axis_reg  <= vrt_pkg::AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // Next state and axis sequencing.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            vrt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vrt_pkg::ST_CHECK;
                end
            end
            vrt_pkg::ST_CHECK:
            begin
                axis_next = vrt_pkg::AXIS_X;
                if (stat.verdict == vrt_pkg::STATUS_VOXEL)
                begin
                    state_next = vrt_pkg::ST_SETUP;
                end
                else
                begin
                    state_next = vrt_pkg::ST_PUSH;
                end
            end
            vrt_pkg::ST_SETUP:
            begin
                if (stat.dir_zero)
                begin
                    if (axis_reg == vrt_pkg::AXIS_Z)
                    begin
                        axis_next  = vrt_pkg::AXIS_X;
                        state_next = vrt_pkg::ST_MUL_LO;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    state_next = vrt_pkg::ST_DIV;
                end
            end
            vrt_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    if (axis_reg == vrt_pkg::AXIS_Z)
                    begin
                        axis_next  = vrt_pkg::AXIS_X;
                        state_next = vrt_pkg::ST_MUL_LO;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = vrt_pkg::ST_SETUP;
                    end
                end
            end
            vrt_pkg::ST_MUL_LO:
            begin
                state_next = vrt_pkg::ST_MUL_HI;
            end
            vrt_pkg::ST_MUL_HI:
            begin
                state_next = vrt_pkg::ST_MOVE;
            end
            vrt_pkg::ST_MOVE:
            begin
                if (axis_reg == vrt_pkg::AXIS_Z)
                begin
                    axis_next  = vrt_pkg::AXIS_X;
                    state_next = vrt_pkg::ST_PUSH;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = vrt_pkg::ST_MUL_LO;
                end
            end
            vrt_pkg::ST_PUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = vrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vrt_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        ctl      = '0;
        ctl.axis = axis_reg;
        in_ready = 1'b0;
        case (state_reg)
            vrt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            vrt_pkg::ST_CHECK:  ctl.decide    = 1'b1;
            vrt_pkg::ST_SETUP:  ctl.div_start = !stat.dir_zero;
            vrt_pkg::ST_DIV:
            begin
                ctl.div_step = !stat.div_done;
                ctl.take     = stat.div_done;
            end
            vrt_pkg::ST_MUL_LO: ctl.mul_lo = 1'b1;
            vrt_pkg::ST_MUL_HI: ctl.mul_hi = 1'b1;
            vrt_pkg::ST_MOVE:   ctl.move   = 1'b1;
            vrt_pkg::ST_PUSH:   ctl.push   = stat.out_free;
            default:            ctl.load   = 1'b0;
        endcase
    end

endmodule

/* hdl/vrt_datapath.sv */
module vrt_datapath
#(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  vrt_pkg::vrt_ctl_t                 ctl,
    output vrt_pkg::vrt_stat_t                stat,
    input  logic                              req_cmd,
    input  logic [vrt_pkg::IO_W-1:0]          start_x,
    input  logic [vrt_pkg::IO_W-1:0]          start_y,
    input  logic [vrt_pkg::IO_W-1:0]          start_z,
    input  logic [vrt_pkg::IO_W-1:0]          end_x,
    input  logic [vrt_pkg::IO_W-1:0]          end_y,
    input  logic [vrt_pkg::IO_W-1:0]          end_z,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vrt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vrt_pkg::IO_W-1:0]          mid_x,
    output logic [vrt_pkg::IO_W-1:0]          mid_y,
    output logic [vrt_pkg::IO_W-1:0]          mid_z,
    output logic [vrt_pkg::FACE_W-1:0]        entry_face,
    output logic [vrt_pkg::STATUS_W-1:0]      status
);

    localparam int PT    = INT_BITS + FRAC_BITS;
    localparam int EXT_W = (PT > vrt_pkg::IO_W) ? PT : vrt_pkg::IO_W;
    localparam int NUM_W = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
    localparam int DW    = NUM_W + FRAC_BITS;
    localparam int RW    = PT + 2;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int PW    = vrt_pkg::TIME_W + PT + 1;
    localparam int MW    = PW - FRAC_BITS;
    localparam int SW    = MW + 2;

    localparam logic signed [EXT_W-1:0] PT_MAX_E = {{(EXT_W-PT+1){1'b0}}, {(PT-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] PT_MIN_E = ~PT_MAX_E;
    localparam logic signed [SW-1:0]    PT_MAX_S = {{(SW-PT+1){1'b0}}, {(PT-1){1'b1}}};
    localparam logic signed [SW-1:0]    PT_MIN_S = ~PT_MAX_S;
    localparam logic [NUM_W-1:0]        NUM_ONE  = NUM_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]        DIV_LEN  = CNT_W'(DW);

    function automatic logic [PT-1:0] sat_in(input logic [vrt_pkg::IO_W-1:0] v);
        logic signed [EXT_W-1:0] e;
        logic [PT-1:0]           r;
        begin
            e = {{(EXT_W-vrt_pkg::IO_W+1){v[vrt_pkg::IO_W-1]}}, v[vrt_pkg::IO_W-2:0]};
            if (e > PT_MAX_E)
                r = PT_MAX_E[PT-1:0];
            else if (e < PT_MIN_E)
                r = PT_MIN_E[PT-1:0];
            else
                r = e[PT-1:0];
            return r;
        end
    endfunction

    function automatic logic [vrt_pkg::IO_W-1:0] to_out(input logic [PT-1:0] v);
        logic [EXT_W-1:0] e;
        begin
            e = {{(EXT_W-PT+1){v[PT-1]}}, v[PT-2:0]};
            return e[vrt_pkg::IO_W-1:0];
        end
    endfunction

    // Configuration registers.
    logic [vrt_pkg::STEP_W-1:0]  step_limit_reg;
    logic [vrt_pkg::NUDGE_W-1:0] floor_nudge_reg;
    logic [vrt_pkg::TIME_W-1:0]  max_time_reg;

    // Ray state.
    logic [PT-1:0]       cur_point_reg [3];
    logic [PT-1:0]       halfway_reg   [3];
    logic [PT:0]         dir_reg       [3];
    logic [INT_BITS-1:0] dest_reg      [3];
    logic [vrt_pkg::FACE_W-1:0] last_face_reg;
    logic [vrt_pkg::STEP_W-1:0] step_count_reg;
    logic                       active_reg;

    // Step working registers.
    logic [vrt_pkg::TIME_W-1:0]   best_reg;
    logic [vrt_pkg::FACE_W-1:0]   side_reg;
    logic [RW-1:0]                div_rem_reg;
    logic [DW-1:0]                div_quo_reg;
    logic [CNT_W-1:0]             div_cnt_reg;
    logic                         div_neg_reg;
    logic [PW-1:0]                acc_reg;
    logic [vrt_pkg::STATUS_W-1:0] res_status_reg;

    // Result register.
    logic                         out_valid_reg;
    logic [vrt_pkg::IO_W-1:0]     mid_x_reg, mid_y_reg, mid_z_reg;
    logic [vrt_pkg::FACE_W-1:0]   face_reg;
    logic [vrt_pkg::STATUS_W-1:0] status_reg;

    logic [PT-1:0]  s_sat [3];
    logic [PT-1:0]  e_sat [3];
    logic [PT-1:0]  p;
    logic [PT:0]    d;
    logic           dneg;
    logic [PT:0]    dmag;
    logic [PT:0]    p_nudged;
    logic [NUM_W-1:0] num;
    logic [RW-1:0]  rem_shift;
    logic [RW-1:0]  rem_diff;
    logic [vrt_pkg::TIME_LO_W+PT:0] mul_lo;
    logic [vrt_pkg::TIME_HI_W+PT:0] mul_hi;
    logic signed [SW-1:0] prev_s, mag_s, sum_s;
    logic [PT-1:0]  new_p;
    logic [PT:0]    half_sum;
    logic           in_dest;
    logic [vrt_pkg::STATUS_W-1:0] verdict;
    logic           out_free;

    always_comb
    begin
        s_sat[0] = sat_in(start_x);
        s_sat[1] = sat_in(start_y);
        s_sat[2] = sat_in(start_z);
        e_sat[0] = sat_in(end_x);
        e_sat[1] = sat_in(end_y);
        e_sat[2] = sat_in(end_z);

        p    = cur_point_reg[ctl.axis];
        d    = dir_reg[ctl.axis];
        dneg = d[PT];
        dmag = dneg ? (~d + 1'b1) : d;

        // Distance to the next face plane along this axis, in Q.FRAC units.
        p_nudged = {p[PT-1], p} - {{(PT+1-vrt_pkg::NUDGE_W){1'b0}}, floor_nudge_reg};
        if (dneg)
            num = {{(NUM_W-vrt_pkg::NUDGE_W){1'b0}}, floor_nudge_reg}
                + {{(NUM_W-FRAC_BITS){1'b0}}, p_nudged[FRAC_BITS-1:0]};
        else
            num = NUM_ONE - {{(NUM_W-FRAC_BITS){1'b0}}, p[FRAC_BITS-1:0]};

        // Restoring division, one quotient bit per cycle.
        rem_shift = {div_rem_reg[RW-2:0], div_quo_reg[DW-1]};
        rem_diff  = rem_shift - {1'b0, dmag};

        mul_lo = best_reg[vrt_pkg::TIME_LO_W-1:0] * dmag;
        mul_hi = best_reg[vrt_pkg::TIME_W-1:vrt_pkg::TIME_LO_W] * dmag;

        prev_s = {{(SW-PT){p[PT-1]}}, p};
        mag_s  = {2'b00, acc_reg[PW-1:FRAC_BITS]};
        sum_s  = dneg ? (prev_s - mag_s) : (prev_s + mag_s);
        if (sum_s > PT_MAX_S)
            new_p = PT_MAX_S[PT-1:0];
        else if (sum_s < PT_MIN_S)
            new_p = PT_MIN_S[PT-1:0];
        else
            new_p = sum_s[PT-1:0];
        half_sum = {p[PT-1], p} + {new_p[PT-1], new_p};

        in_dest = (halfway_reg[0][PT-1:FRAC_BITS] == dest_reg[0])
               && (halfway_reg[1][PT-1:FRAC_BITS] == dest_reg[1])
               && (halfway_reg[2][PT-1:FRAC_BITS] == dest_reg[2]);
        if (!active_reg)
            verdict = vrt_pkg::STATUS_NONE;
        else if (in_dest)
            verdict = vrt_pkg::STATUS_DEST;
        else if (step_count_reg >= step_limit_reg)
            verdict = vrt_pkg::STATUS_LIMIT;
        else
            verdict = vrt_pkg::STATUS_VOXEL;

        out_free = !out_valid_reg || out_ready;
    end

    assign stat.verdict  = verdict;
    assign stat.dir_zero = (d == '0);
    assign stat.div_done = (div_cnt_reg == '0);
    assign stat.out_free = out_free;

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign mid_x      = mid_x_reg;
    assign mid_y      = mid_y_reg;
    assign mid_z      = mid_z_reg;
    assign entry_face = face_reg;
    assign status     = status_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg  <= vrt_pkg::STEP_LIMIT_RST;
            floor_nudge_reg <= vrt_pkg::FLOOR_NUDGE_RST;
            max_time_reg    <= vrt_pkg::MAX_TIME_RST;
            last_face_reg   <= vrt_pkg::FACE_FRONT;
            step_count_reg  <= '0;
            active_reg      <= 1'b0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    vrt_pkg::CFG_STEP_LIMIT:
                        step_limit_reg <= cfg_data[vrt_pkg::STEP_W-1:0];
                    vrt_pkg::CFG_FLOOR_NUDGE:
                        floor_nudge_reg <= cfg_data[vrt_pkg::NUDGE_W-1:0];
                    vrt_pkg::CFG_MAX_TIME:
                        max_time_reg <= cfg_data[vrt_pkg::TIME_W-1:0];
                    default:
                        max_time_reg <= max_time_reg;
                endcase
            end

            if (ctl.load && req_cmd == vrt_pkg::CMD_START)
            begin
                last_face_reg  <= vrt_pkg::FACE_FRONT;
                step_count_reg <= '0;
                active_reg     <= 1'b1;
            end

            if (ctl.decide
                && (verdict == vrt_pkg::STATUS_DEST || verdict == vrt_pkg::STATUS_LIMIT))
            begin
                active_reg <= 1'b0;
            end

            if (ctl.div_start)
                div_cnt_reg <= DIV_LEN;
            else if (ctl.div_step)
                div_cnt_reg <= div_cnt_reg - 1'b1;

            if (ctl.push && res_status_reg == vrt_pkg::STATUS_VOXEL)
            begin
                last_face_reg  <= side_reg;
                step_count_reg <= step_count_reg + 1'b1;
            end

            if (ctl.push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (ctl.load && req_cmd == vrt_pkg::CMD_START)
        begin
            cur_point_reg[0] <= s_sat[0];
            cur_point_reg[1] <= s_sat[1];
            cur_point_reg[2] <= s_sat[2];
            halfway_reg[0]   <= s_sat[0];
            halfway_reg[1]   <= s_sat[1];
            halfway_reg[2]   <= s_sat[2];
            dir_reg[0] <= {e_sat[0][PT-1], e_sat[0]} - {s_sat[0][PT-1], s_sat[0]};
            dir_reg[1] <= {e_sat[1][PT-1], e_sat[1]} - {s_sat[1][PT-1], s_sat[1]};
            dir_reg[2] <= {e_sat[2][PT-1], e_sat[2]} - {s_sat[2][PT-1], s_sat[2]};
            dest_reg[0] <= e_sat[0][PT-1:FRAC_BITS];
            dest_reg[1] <= e_sat[1][PT-1:FRAC_BITS];
            dest_reg[2] <= e_sat[2][PT-1:FRAC_BITS];
        end

        if (ctl.decide)
        begin
            res_status_reg <= verdict;
            best_reg       <= max_time_reg;
            side_reg       <= last_face_reg;
        end

        if (ctl.div_start)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= {num, {FRAC_BITS{1'b0}}};
            div_neg_reg <= dneg;
        end
        else if (ctl.div_step)
        begin
            div_quo_reg <= {div_quo_reg[DW-2:0], ~rem_diff[RW-1]};
            div_rem_reg <= rem_diff[RW-1] ? rem_shift : rem_diff;
        end

        // Strict compare keeps the lower axis on a tie.
        if (ctl.take && div_quo_reg < {{(DW-vrt_pkg::TIME_W){1'b0}}, best_reg})
        begin
            best_reg <= div_quo_reg[vrt_pkg::TIME_W-1:0];
            side_reg <= vrt_pkg::axis_face(ctl.axis, div_neg_reg);
        end

        if (ctl.mul_lo)
            acc_reg <= {{(PW-vrt_pkg::TIME_LO_W-PT-1){1'b0}}, mul_lo};
        else if (ctl.mul_hi)
            acc_reg <= acc_reg + {mul_hi, {vrt_pkg::TIME_LO_W{1'b0}}};

        if (ctl.move)
        begin
            cur_point_reg[ctl.axis] <= new_p;
            halfway_reg[ctl.axis]   <= half_sum[PT:1];
        end

        if (ctl.push)
        begin
            status_reg <= res_status_reg;
            if (res_status_reg == vrt_pkg::STATUS_NONE)
            begin
                mid_x_reg <= '0;
                mid_y_reg <= '0;
                mid_z_reg <= '0;
                face_reg  <= vrt_pkg::FACE_FRONT;
            end
            else
            begin
                mid_x_reg <= to_out(halfway_reg[0]);
                mid_y_reg <= to_out(halfway_reg[1]);
                mid_z_reg <= to_out(halfway_reg[2]);
                face_reg  <= last_face_reg;
            end
        end
    end

endmodule

/* test/tb_voxel_ray_traversal_core.sv */
`timescale 1ns / 100ps

// Testbench for the voxel ray traversal core.
//
// Requests are sent one at a time on the input channel. Each accepted request is run
// through a predictor kept in this file, which tracks the ray state and configuration of
// the block. The predicted result is queued, and a checker process compares every result
// leaving the block, field by field, with the oldest queued prediction.
//
// Configuration registers are only written while the block is idle, which means after
// reset or once every predicted result has been seen. The run steps through several
// register settings, including both ends of each range.
//
// Stimulus starts with a set of directed tests: no active ray, a ray that starts inside its
// destination, single-axis rays in each direction, zero direction axes, a zero nudge with a
// point on a grid plane, extreme coordinates, and register extremes. After that come random
// traversals in four idling phases. The sender and the receiver idle at random, and one
// test holds the receiver off for a long stretch so that the block fills up and stalls its
// input.
module tb_voxel_ray_traversal_core;

    localparam int FRAC  = 16;
    localparam longint ONE_FX = 64'sd1 <<< FRAC;
    localparam longint PT_MAX = 64'sd2147483647;
    localparam longint PT_MIN = -64'sd2147483648;

    // One predicted result, laid out like the output ports.
    typedef struct {
        logic [vrt_pkg::IO_W-1:0]     mid_x;
        logic [vrt_pkg::IO_W-1:0]     mid_y;
        logic [vrt_pkg::IO_W-1:0]     mid_z;
        logic [vrt_pkg::FACE_W-1:0]   face;
        logic [vrt_pkg::STATUS_W-1:0] status;
    } voxel_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           cmd;
    logic [vrt_pkg::IO_W-1:0]       start_x;
    logic [vrt_pkg::IO_W-1:0]       start_y;
    logic [vrt_pkg::IO_W-1:0]       start_z;
    logic [vrt_pkg::IO_W-1:0]       end_x;
    logic [vrt_pkg::IO_W-1:0]       end_y;
    logic [vrt_pkg::IO_W-1:0]       end_z;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [vrt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [vrt_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           out_valid;
    logic                           out_ready;
    logic [vrt_pkg::IO_W-1:0]       mid_x;
    logic [vrt_pkg::IO_W-1:0]       mid_y;
    logic [vrt_pkg::IO_W-1:0]       mid_z;
    logic [vrt_pkg::FACE_W-1:0]     entry_face;
    logic [vrt_pkg::STATUS_W-1:0]   status;

    voxel_ray_traversal_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .end_x      (end_x),
        .end_y      (end_y),
        .end_z      (end_z),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mid_x      (mid_x),
        .mid_y      (mid_y),
        .mid_z      (mid_z),
        .entry_face (entry_face),
        .status     (status)
    );

    // A 4 ns clock.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow copy of the block's registers and ray state, kept by the predictor.
    longint unsigned lim_steps;
    longint unsigned nudge;
    longint unsigned time_cap;
    longint          pos[3];
    longint          half[3];
    longint          dir[3];
    longint          dest[3];
    logic [vrt_pkg::FACE_W-1:0] prev_face;
    longint unsigned steps_taken;
    bit              ray_on;

    voxel_result_t   pending_results[$];
    int unsigned     mismatches;
    int unsigned     sender_idle_pct;
    int unsigned     receiver_stall_pct;
    int unsigned     hold_off_cycles;
    int unsigned     requests_sent;

    function automatic longint clamp_point(input longint v);
        if (v > PT_MAX)
            return PT_MAX;
        if (v < PT_MIN)
            return PT_MIN;
        return v;
    endfunction

    // One traversal step: find the earliest face crossing and move the point there.
    function automatic void step_ray();
        longint unsigned best;
        longint unsigned t;
        longint unsigned num;
        longint unsigned mag;
        longint          v;
        longint          d;
        longint          p;
        longint          prev;
        logic [vrt_pkg::FACE_W-1:0] side;
        logic [vrt_pkg::FACE_W-1:0] pos_face[3];
        logic [vrt_pkg::FACE_W-1:0] neg_face[3];
        best = time_cap;
        side = prev_face;
        pos_face = '{vrt_pkg::FACE_BACK, vrt_pkg::FACE_BOTTOM, vrt_pkg::FACE_LEFT};
        neg_face = '{vrt_pkg::FACE_FRONT, vrt_pkg::FACE_TOP, vrt_pkg::FACE_RIGHT};
        for (int a = 0; a < 3; a++)
        begin
            d = dir[a];
            p = pos[a];
            if (d > 0)
            begin
                v = p >>> FRAC;
                num = longint'((v + 1) * ONE_FX - p);
                t = (num << FRAC) / longint'(d);
                if (t < best)
                begin
                    best = t;
                    side = pos_face[a];
                end
            end
            else if (d < 0)
            begin
                v = (p - longint'(nudge)) >>> FRAC;
                num = longint'(p - v * ONE_FX);
                t = (num << FRAC) / longint'(-d);
                if (t < best)
                begin
                    best = t;
                    side = neg_face[a];
                end
            end
        end
        // The product fits in 64 bits, as the block's arithmetic does.
        for (int a = 0; a < 3; a++)
        begin
            d = dir[a];
            prev = pos[a];
            mag = (best * longint'(d < 0 ? -d : d)) >> FRAC;
            if (d < 0)
                pos[a] = clamp_point(prev - longint'(mag));
            else
                pos[a] = clamp_point(prev + longint'(mag));
            half[a] = (prev + pos[a]) >>> 1;
        end
        prev_face = side;
        steps_taken++;
    endfunction

    // Predicts the result of one accepted request and updates the shadow state.
    function automatic voxel_result_t predict_voxel(input logic c,
                                                    input logic [vrt_pkg::IO_W-1:0] s[3],
                                                    input logic [vrt_pkg::IO_W-1:0] e[3]);
        voxel_result_t r;
        logic [vrt_pkg::FACE_W-1:0] face;
        bit at_dest;
        if (c == vrt_pkg::CMD_START)
        begin
            for (int a = 0; a < 3; a++)
            begin
                pos[a]  = longint'(signed'(s[a]));
                half[a] = pos[a];
                dir[a]  = longint'(signed'(e[a])) - pos[a];
                dest[a] = longint'(signed'(e[a])) >>> FRAC;
            end
            prev_face = vrt_pkg::FACE_FRONT;
            steps_taken = 0;
            ray_on = 1'b1;
        end
        if (!ray_on)
        begin
            r = '{0, 0, 0, vrt_pkg::FACE_FRONT, vrt_pkg::STATUS_NONE};
            return r;
        end
        at_dest = 1'b1;
        for (int a = 0; a < 3; a++)
            if ((half[a] >>> FRAC) != dest[a])
                at_dest = 1'b0;
        if (at_dest || steps_taken >= lim_steps)
        begin
            ray_on = 1'b0;
            r = '{half[0][31:0], half[1][31:0], half[2][31:0], prev_face,
                  at_dest ? vrt_pkg::STATUS_DEST : vrt_pkg::STATUS_LIMIT};
            return r;
        end
        face = prev_face;
        step_ray();
        r = '{half[0][31:0], half[1][31:0], half[2][31:0], face, vrt_pkg::STATUS_VOXEL};
        return r;
    endfunction

    // Sends one request, after a random gap, and predicts its result once accepted.
    task automatic send_request(input logic c, input logic [vrt_pkg::IO_W-1:0] s[3],
                                input logic [vrt_pkg::IO_W-1:0] e[3]);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd      <= c;
        start_x  <= s[0];
        start_y  <= s[1];
        start_z  <= s[2];
        end_x    <= e[0];
        end_y    <= e[1];
        end_z    <= e[2];
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_voxel(c, s, e));
        requests_sent++;
    endtask

    task automatic send_continue();
        logic [vrt_pkg::IO_W-1:0] z[3];
        z = '{$urandom, $urandom, $urandom};
        send_request(vrt_pkg::CMD_CONTINUE, z, z);
    endtask

    // Starts a ray and follows it with continue requests until it ends or runs long.
    task automatic trace_ray(input logic [vrt_pkg::IO_W-1:0] s[3],
                             input logic [vrt_pkg::IO_W-1:0] e[3],
                             input int unsigned max_requests);
        int unsigned n;
        send_request(vrt_pkg::CMD_START, s, e);
        n = 1;
        while (ray_on && n < max_requests)
        begin
            send_continue();
            n++;
        end
    endtask

    // Lowers valid and waits until every predicted result has been seen, plus some margin
    // for a request that may still be in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vrt_pkg::CFG_IDX_W-1:0] idx,
                             input longint unsigned value);
        wait_idle();
        cfg_index <= idx;
        cfg_data  <= value[vrt_pkg::CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == vrt_pkg::CFG_STEP_LIMIT)
            lim_steps = value & 64'h3FF;
        else if (idx == vrt_pkg::CFG_FLOOR_NUDGE)
            nudge = value & 64'hFFFF;
        else if (idx == vrt_pkg::CFG_MAX_TIME)
            time_cap = value & 64'h7FFF_FFFF;
    endtask

    function automatic logic [vrt_pkg::IO_W-1:0] fx(input int whole, input int unsigned frac);
        return vrt_pkg::IO_W'((longint'(whole) <<< FRAC) + frac);
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Checker: every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        voxel_result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: mid %h %h %h face %0d status %0d",
                             mid_x, mid_y, mid_z, entry_face, status);
            end
            else
            begin
                w = pending_results.pop_front();
                if (mid_x !== w.mid_x || mid_y !== w.mid_y || mid_z !== w.mid_z ||
                    entry_face !== w.face || status !== w.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result error: expected mid %h %h %h face %0d status %0d,",
                                  " got mid %h %h %h face %0d status %0d"},
                                 w.mid_x, w.mid_y, w.mid_z, w.face, w.status,
                                 mid_x, mid_y, mid_z, entry_face, status);
                end
            end
        end
    end

    // A continue request with no ray loaded must come back with status none.
    task automatic test_no_active_ray();
        send_continue();
        send_continue();
    endtask

    // A ray whose start lies in its destination voxel ends at once.
    task automatic test_start_in_dest();
        logic [vrt_pkg::IO_W-1:0] s[3];
        logic [vrt_pkg::IO_W-1:0] e[3];
        s = '{fx(2, 16'h1000), fx(-3, 16'h8000), fx(0, 0)};
        e = '{fx(2, 16'hF000), fx(-3, 16'h0001), fx(0, 16'hFFFF)};
        trace_ray(s, e, 4);
        send_continue();
    endtask

    // Single-axis rays in each direction cover all six entry faces.
    task automatic test_axis_rays();
        logic [vrt_pkg::IO_W-1:0] s[3];
        logic [vrt_pkg::IO_W-1:0] e[3];
        for (int a = 0; a < 3; a++)
        begin
            s = '{fx(0, 16'h8000), fx(0, 16'h8000), fx(0, 16'h8000)};
            e = s;
            e[a] = fx(3, 16'h4000);
            trace_ray(s, e, 8);
            e[a] = fx(-3, 16'h4000);
            trace_ray(s, e, 8);
        end
        // Diagonal ray through a grid corner, where ties go to the lower axis.
        trace_ray('{fx(0, 0), fx(0, 0), fx(0, 0)}, '{fx(3, 0), fx(3, 0), fx(3, 0)}, 12);
    endtask

    // Extreme coordinates, a limit of zero steps and a capped crossing time.
    task automatic test_extremes();
        write_reg(vrt_pkg::CFG_STEP_LIMIT, 3);
        trace_ray('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
                  '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 6);
        trace_ray('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                  '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 6);
        write_reg(vrt_pkg::CFG_STEP_LIMIT, 0);
        trace_ray('{fx(1, 0), fx(1, 0), fx(1, 0)}, '{fx(5, 0), fx(1, 0), fx(1, 0)}, 3);
        write_reg(vrt_pkg::CFG_MAX_TIME, 0);
        write_reg(vrt_pkg::CFG_STEP_LIMIT, 2);
        trace_ray('{fx(1, 0), fx(1, 0), fx(1, 0)}, '{fx(5, 0), fx(-4, 0), fx(1, 0)}, 5);
        write_reg(vrt_pkg::CFG_MAX_TIME, 64'h7FFF_FFFF);
        write_reg(vrt_pkg::CFG_STEP_LIMIT, 1023);
        trace_ray('{fx(0, 16'h0100), fx(0, 0), fx(0, 0)},
                  '{fx(9000, 0), fx(1, 16'h0010), fx(0, 16'h0001)}, 3);
    endtask

    // A zero nudge stalls a point on a plane with negative direction; then nudge 65535.
    task automatic test_zero_nudge();
        write_reg(vrt_pkg::CFG_FLOOR_NUDGE, 0);
        write_reg(vrt_pkg::CFG_STEP_LIMIT, 3);
        trace_ray('{fx(2, 0), fx(0, 16'h4000), fx(0, 16'h4000)},
                  '{fx(-1, 16'h8000), fx(0, 16'h4000), fx(0, 16'h4000)}, 6);
        write_reg(vrt_pkg::CFG_FLOOR_NUDGE, 65535);
        trace_ray('{fx(2, 0), fx(1, 0), fx(0, 16'h4000)},
                  '{fx(-1, 16'h8000), fx(-2, 0), fx(0, 16'h4000)}, 6);
    endtask

    // The receiver holds off while the sender keeps offering requests, so the output
    // register fills and the input channel stalls.
    task automatic test_back_pressure();
        logic [vrt_pkg::IO_W-1:0] s[3];
        logic [vrt_pkg::IO_W-1:0] e[3];
        write_reg(vrt_pkg::CFG_STEP_LIMIT, 1023);
        write_reg(vrt_pkg::CFG_FLOOR_NUDGE, 328);
        write_reg(vrt_pkg::CFG_MAX_TIME, 13107200);
        s = '{fx(0, 16'h1234), fx(0, 16'h5678), fx(0, 16'h9ABC)};
        e = '{fx(6, 16'h1111), fx(-4, 16'h2222), fx(5, 16'h3333)};
        hold_off_cycles = 1200;
        trace_ray(s, e, 40);
    endtask

    function automatic logic [vrt_pkg::IO_W-1:0] rand_coord(input int span);
        return fx($urandom_range(2 * span) - span, $urandom_range(16'hFFFF));
    endfunction

    // Mostly well-formed traversals with random content, plus noise: stray continues,
    // rays dropped partway by a new start, and full-range endpoints.
    task automatic test_random_rays(input int unsigned count);
        logic [vrt_pkg::IO_W-1:0] s[3];
        logic [vrt_pkg::IO_W-1:0] e[3];
        int unsigned goal;
        int unsigned pick;
        goal = requests_sent + count;
        while (requests_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                send_continue();
            end
            else if (pick < 10)
            begin
                s = '{$urandom, $urandom, $urandom};
                e = '{$urandom, $urandom, $urandom};
                trace_ray(s, e, $urandom_range(1, 12));
            end
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    s[a] = rand_coord(16);
                    e[a] = ($urandom_range(9) == 0) ? s[a] : s[a] + rand_coord(5);
                end
                trace_ray(s, e, (pick < 20) ? $urandom_range(1, 4) : 200);
            end
        end
    endtask

    task automatic random_config();
        write_reg(vrt_pkg::CFG_STEP_LIMIT, $urandom_range(4, 40));
        write_reg(vrt_pkg::CFG_FLOOR_NUDGE, ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                                                       : $urandom_range(1000));
        write_reg(vrt_pkg::CFG_MAX_TIME, ($urandom_range(3) == 0)
                                         ? $urandom_range(32'h7FFF_FFFF)
                                         : $urandom_range(1 << 16, 1 << 24));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = vrt_pkg::CMD_START;
        start_x = '0;
        start_y = '0;
        start_z = '0;
        end_x = '0;
        end_y = '0;
        end_z = '0;
        cfg_valid = 1'b0;
        cfg_index = vrt_pkg::CFG_STEP_LIMIT;
        cfg_data = '0;
        mismatches = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        requests_sent = 0;
        lim_steps = vrt_pkg::STEP_LIMIT_RST;
        nudge = vrt_pkg::FLOOR_NUDGE_RST;
        time_cap = vrt_pkg::MAX_TIME_RST;
        pos = '{0, 0, 0};
        half = '{0, 0, 0};
        dir = '{0, 0, 0};
        dest = '{0, 0, 0};
        prev_face = vrt_pkg::FACE_FRONT;
        steps_taken = 0;
        ray_on = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed tests, with no random idling on either side.
        test_no_active_ray();
        test_start_in_dest();
        test_axis_rays();
        test_extremes();
        test_zero_nudge();
        test_back_pressure();

        // Random traversals, one idling phase at a time.
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        random_config();
        test_random_rays(370);
        sender_idle_pct = 48;
        receiver_stall_pct = 0;
        random_config();
        test_random_rays(370);
        sender_idle_pct = 0;
        receiver_stall_pct = 48;
        random_config();
        test_random_rays(370);
        sender_idle_pct = 32;
        receiver_stall_pct = 32;
        random_config();
        test_random_rays(370);

        wait_idle();
        repeat (150) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("voxel_ray_traversal_core: match");
        else
            $display("voxel_ray_traversal_core: mismatch");
        $finish;
    end

    // Watchdog, well beyond the slowest correct run.
    initial
    begin
        #40_000_000;
        $display("voxel_ray_traversal_core: mismatch");
        $finish;
    end

endmodule

/* files.f */
hdl/vrt_pkg.sv
hdl/vrt_ctrl.sv
hdl/vrt_datapath.sv
hdl/voxel_ray_traversal_core.sv
test/tb_voxel_ray_traversal_core.sv
